/* rtl/pis_pkg.sv */
// ----------------------------------------------------------------------------
// pis_pkg
// Shared types and constants of the perturbation island segmenter.
// ----------------------------------------------------------------------------
package pis_pkg;

  localparam int PIS_MAX_CELLS = 65536;

  localparam int POS_W   = 16;
  localparam int DIFF_W  = 17;
  localparam int CLU_W   = 16;
  localparam int GAP_W   = 4;
  localparam int QUIET_W = 5;
  localparam int OC_W    = 2;

  localparam logic [GAP_W-1:0]  GAP_RESET = 4'd3;
  localparam logic [DIFF_W-1:0] DIFF_MAX  = '1;
  localparam logic [CLU_W-1:0]  CLU_MAX   = '1;

  // result kinds
  localparam logic KIND_ISLAND  = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // outcome codes
  localparam logic [OC_W-1:0] OC_UNKNOWN      = 2'd0;
  localparam logic [OC_W-1:0] OC_ANNIHILATION = 2'd1;
  localparam logic [OC_W-1:0] OC_NEW_PARTS    = 2'd2;
  localparam logic [OC_W-1:0] OC_PASSTHROUGH  = 2'd3;

  // result queue depth, power of two, at least 2
  localparam int RESQ_DEPTH = 4;

  typedef struct packed {
    logic cell_value;
    logic ether_value;
    logic pass_after;
    logic last_cell;
  } pis_item_t;

  typedef struct packed {
    logic              result_kind;
    logic [POS_W-1:0]  island_start;
    logic [POS_W-1:0]  island_end;
    logic [DIFF_W-1:0] diff_total;
    logic [CLU_W-1:0]  cluster_total;
    logic [OC_W-1:0]   outcome;
    logic              last_result;
  } pis_result_t;

  // results produced by one processed item, in order
  typedef struct packed {
    logic [1:0]  cnt;
    pis_result_t r0;
    pis_result_t r1;
  } pis_push_t;

endpackage

/* rtl/pis_ifs.sv */
// ----------------------------------------------------------------------------
// pis_in_if / pis_out_if
// Valid/ready channels of the segmenter: cell pairs in, results out.
// ----------------------------------------------------------------------------
interface pis_in_if;
  logic valid;
  logic ready;
  logic cell_value;
  logic ether_value;
  logic pass_after;
  logic last_cell;

  modport source (output valid, cell_value, ether_value, pass_after, last_cell,
                  input ready);
  modport sink   (input valid, cell_value, ether_value, pass_after, last_cell,
                  output ready);
endinterface

interface pis_out_if;
  logic                       valid;
  logic                       ready;
  logic                       result_kind;
  logic [pis_pkg::POS_W-1:0]  island_start;
  logic [pis_pkg::POS_W-1:0]  island_end;
  logic [pis_pkg::DIFF_W-1:0] diff_total;
  logic [pis_pkg::CLU_W-1:0]  cluster_total;
  logic [pis_pkg::OC_W-1:0]   outcome;
  logic                       last_result;

  modport source (output valid, result_kind, island_start, island_end, diff_total,
                         cluster_total, outcome, last_result,
                  input ready);
  modport sink   (input valid, result_kind, island_start, island_end, diff_total,
                        cluster_total, outcome, last_result,
                  output ready);
endinterface

/* rtl/perturbation_island_segmenter.sv */
// ----------------------------------------------------------------------------
// perturbation_island_segmenter
// Counts differing cells per row pass, groups them into islands and reports
// island records of after passes, pass summaries and the before/after outcome.
// ----------------------------------------------------------------------------
// A cell pair waits in the input register, then its results enter the result queue.
// Throughput: one cell pair per cycle while the queue has room; a cell causing two
//   results (island record plus summary) is absorbed by the 4-entry result queue.
// Input accepted when the input register is free or the queue has room for two.
// Reset (rst_n low, synchronous): counters, island tracker and stored before-pass
//   counts clear, the queue empties and gap_limit returns to 3.
module perturbation_island_segmenter #(
  parameter int MAX_CELLS = pis_pkg::PIS_MAX_CELLS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [pis_pkg::GAP_W-1:0] cfg_data,
  pis_in_if.sink                    in_bus,
  pis_out_if.source                 out_bus
);
  import pis_pkg::*;

  pis_push_t push;
  logic      room_ok;

  pis_core #(
    .MAX_CELLS (MAX_CELLS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_bus   (in_bus),
    .room_ok  (room_ok),
    .push     (push)
  );

  pis_resq u_resq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .room_ok (room_ok),
    .out_bus (out_bus)
  );

endmodule

/* rtl/pis_core.sv */
// ----------------------------------------------------------------------------
// pis_core
// Input register, row state and combinational island/summary evaluation.
// ----------------------------------------------------------------------------
module pis_core #(
  parameter int MAX_CELLS = pis_pkg::PIS_MAX_CELLS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [pis_pkg::GAP_W-1:0] cfg_data,
  pis_in_if.sink                    in_bus,
  input  logic                      room_ok,
  output pis_pkg::pis_push_t        push
);
  import pis_pkg::*;

  localparam int POS_LIMIT_I = (MAX_CELLS - 1 < 65535) ? MAX_CELLS - 1 : 65535;
  localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(POS_LIMIT_I);

  logic [GAP_W-1:0]   gap_limit_r;
  pis_item_t          item_r;
  logic               item_v_r;
  logic [POS_W-1:0]   position_r,   position_nxt;
  logic [DIFF_W-1:0]  diff_r,       diff_nxt,   diff_upd;
  logic [CLU_W-1:0]   clu_r,        clu_nxt,    clu_upd;
  logic               island_r,     island_nxt, island_upd;
  logic [QUIET_W-1:0] quiet_r,      quiet_nxt,  quiet_upd;
  logic [POS_W-1:0]   first_r,      first_nxt;
  logic [POS_W-1:0]   latest_r,     latest_nxt;
  logic [DIFF_W-1:0]  bdiff_r,      bdiff_nxt;
  logic [CLU_W-1:0]   bclu_r,       bclu_nxt;
  logic               proceed, differs, gap_close, rec_emit;
  logic [OC_W-1:0]    oc;
  pis_result_t        rec, summ;

  assign proceed      = item_v_r && room_ok;
  assign in_bus.ready = !item_v_r || room_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_limit_r <= GAP_RESET;
    end else if (cfg_we) begin
      gap_limit_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
    end else if (in_bus.valid && in_bus.ready) begin
      item_v_r <= 1'b1;
    end else if (proceed) begin
      item_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      item_r.cell_value  <= in_bus.cell_value;
      item_r.ether_value <= in_bus.ether_value;
      item_r.pass_after  <= in_bus.pass_after;
      item_r.last_cell   <= in_bus.last_cell;
    end
  end

  assign differs = item_r.cell_value ^ item_r.ether_value;

  // cell update, before any row-end handling
  always_comb begin
    diff_upd   = diff_r;
    clu_upd    = clu_r;
    island_upd = island_r;
    quiet_upd  = quiet_r;
    first_nxt  = first_r;
    latest_nxt = latest_r;
    gap_close  = 1'b0;
    if (differs) begin
      if (diff_r != DIFF_MAX) diff_upd = diff_r + 1'b1;
      if (!island_r) begin
        if (clu_r != CLU_MAX) clu_upd = clu_r + 1'b1;
        first_nxt  = position_r;
        island_upd = 1'b1;
      end
      latest_nxt = position_r;
      quiet_upd  = '0;
    end else if (island_r) begin
      quiet_upd = quiet_r + 1'b1;
      if (quiet_upd > QUIET_W'(gap_limit_r)) begin
        gap_close  = 1'b1;
        island_upd = 1'b0;
        quiet_upd  = '0;
      end
    end
  end

  always_comb begin
    if (bdiff_r == '0 || bclu_r == '0) begin
      oc = OC_UNKNOWN;
    end else if (diff_upd == '0 || clu_upd == '0) begin
      oc = OC_ANNIHILATION;
    end else if (clu_upd > bclu_r) begin
      oc = OC_NEW_PARTS;
    end else if ((bclu_r - clu_upd) <= CLU_W'(1)) begin
      oc = OC_PASSTHROUGH;
    end else begin
      oc = OC_UNKNOWN;
    end
  end

  // at most one island record per cell: a gap close leaves nothing open at row end
  assign rec_emit = item_r.pass_after &&
                    (gap_close || (item_r.last_cell && island_upd));

  always_comb begin
    rec               = '0;
    rec.result_kind   = KIND_ISLAND;
    rec.island_start  = first_nxt;
    rec.island_end    = latest_nxt;
    rec.last_result   = !item_r.last_cell;
    summ              = '0;
    summ.result_kind  = KIND_SUMMARY;
    summ.diff_total   = diff_upd;
    summ.cluster_total = clu_upd;
    summ.outcome      = item_r.pass_after ? oc : OC_UNKNOWN;
    summ.last_result  = 1'b1;
  end

  always_comb begin
    push = '0;
    if (proceed) begin
      push.cnt = {1'b0, rec_emit} + {1'b0, item_r.last_cell};
      push.r0  = rec_emit ? rec : summ;
      push.r1  = summ;
    end
  end

  always_comb begin
    position_nxt = position_r;
    diff_nxt     = diff_upd;
    clu_nxt      = clu_upd;
    island_nxt   = island_upd;
    quiet_nxt    = quiet_upd;
    bdiff_nxt    = bdiff_r;
    bclu_nxt     = bclu_r;
    if (item_r.last_cell) begin
      if (!item_r.pass_after) begin
        bdiff_nxt = diff_upd;
        bclu_nxt  = clu_upd;
      end
      diff_nxt     = '0;
      clu_nxt      = '0;
      island_nxt   = 1'b0;
      quiet_nxt    = '0;
      position_nxt = '0;
    end else if (position_r < POS_LIMIT) begin
      position_nxt = position_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_r <= '0;
      diff_r     <= '0;
      clu_r      <= '0;
      island_r   <= 1'b0;
      quiet_r    <= '0;
      first_r    <= '0;
      latest_r   <= '0;
      bdiff_r    <= '0;
      bclu_r     <= '0;
    end else if (proceed) begin
      position_r <= position_nxt;
      diff_r     <= diff_nxt;
      clu_r      <= clu_nxt;
      island_r   <= island_nxt;
      quiet_r    <= quiet_nxt;
      first_r    <= first_nxt;
      latest_r   <= latest_nxt;
      bdiff_r    <= bdiff_nxt;
      bclu_r     <= bclu_nxt;
    end
  end

endmodule

/* rtl/pis_resq.sv */
// ----------------------------------------------------------------------------
// pis_resq
// Small result queue: takes up to two results a cycle, hands out one.
// ----------------------------------------------------------------------------
module pis_resq (
  input  logic               clk,
  input  logic               rst_n,
  input  pis_pkg::pis_push_t push,
  output logic               room_ok,
  pis_out_if.source          out_bus
);
  import pis_pkg::*;

  localparam int PTR_W = $clog2(RESQ_DEPTH);
  localparam int CNT_W = $clog2(RESQ_DEPTH + 1);
  localparam logic [CNT_W-1:0] ROOM_MAX = CNT_W'(RESQ_DEPTH - 2);

  pis_result_t        mem_r [RESQ_DEPTH];
  logic [PTR_W-1:0]   wr_r, wr_nxt, rd_r, rd_nxt, wr_p1;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               pop;
  pis_result_t        head;

  assign head    = mem_r[rd_r];
  assign pop     = out_bus.valid && out_bus.ready;
  assign room_ok = cnt_r <= ROOM_MAX;
  assign wr_p1   = wr_r + 1'b1;

  assign out_bus.valid         = cnt_r != '0;
  assign out_bus.result_kind   = head.result_kind;
  assign out_bus.island_start  = head.island_start;
  assign out_bus.island_end    = head.island_end;
  assign out_bus.diff_total    = head.diff_total;
  assign out_bus.cluster_total = head.cluster_total;
  assign out_bus.outcome       = head.outcome;
  assign out_bus.last_result   = head.last_result;

  always_comb begin
    wr_nxt  = wr_r + PTR_W'(push.cnt);
    rd_nxt  = pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + CNT_W'(push.cnt) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) mem_r[wr_r] <= push.r0;
    if (push.cnt == 2'd2) mem_r[wr_p1] <= push.r1;
  end

endmodule

/* rtl/pis_checker.sv */
// ----------------------------------------------------------------------------
// pis_checker
// Port-level checks of the segmenter, bound to the top level.
// ----------------------------------------------------------------------------
module pis_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       result_kind,
  input logic [pis_pkg::POS_W-1:0]  island_start,
  input logic [pis_pkg::POS_W-1:0]  island_end,
  input logic [pis_pkg::DIFF_W-1:0] diff_total,
  input logic [pis_pkg::CLU_W-1:0]  cluster_total,
  input logic [pis_pkg::OC_W-1:0]   outcome,
  input logic                       last_result
);
  import pis_pkg::*;

  // stalled transaction holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(result_kind) &&
    $stable(island_start) && $stable(island_end) && $stable(diff_total) &&
    $stable(cluster_total) && $stable(outcome) && $stable(last_result))
    else $error("output payload changed while stalled");

  a_rec_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && result_kind == KIND_ISLAND |->
    diff_total == '0 && cluster_total == '0 && outcome == OC_UNKNOWN &&
    island_start <= island_end)
    else $error("malformed island record");

  a_summ_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && result_kind == KIND_SUMMARY |->
    last_result && island_start == '0 && island_end == '0)
    else $error("summary not final or carries island positions");

  // every island opens on a differing cell
  a_clu_le_diff: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && result_kind == KIND_SUMMARY |->
    {1'b0, cluster_total} <= diff_total)
    else $error("more islands than differing cells");

endmodule

bind perturbation_island_segmenter pis_checker u_pis_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_bus.valid),
  .out_ready     (out_bus.ready),
  .result_kind   (out_bus.result_kind),
  .island_start  (out_bus.island_start),
  .island_end    (out_bus.island_end),
  .diff_total    (out_bus.diff_total),
  .cluster_total (out_bus.cluster_total),
  .outcome       (out_bus.outcome),
  .last_result   (out_bus.last_result)
);
